[src/gbpe_pkg.sv]
// ----------------------------------------------------------------------------
// gbpe_pkg
// Shared types and constants for the glyph bitmap pixel expander.
// ----------------------------------------------------------------------------
package gbpe_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int CNT_W      = 3;
   localparam int HEIGHT_W   = 7;
   localparam int COLOR_W    = 16;
   localparam int PIX_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd16;
   localparam logic [COLOR_W-1:0]  FORE_RESET   = 16'hFFFF;
   localparam logic [COLOR_W-1:0]  BACK_RESET   = 16'h0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLYPH_HEIGHT = 2'd0,
      CSR_FORE_COLOR   = 2'd1,
      CSR_BACK_COLOR   = 2'd2
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // take a new font byte
      logic emit;   // issue one pixel into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;   // the pixel at the cursor ends this byte
   } status_type;

endpackage

[src/gbpe_if.sv]
// ----------------------------------------------------------------------------
// gbpe_req_if / gbpe_rsp_if
// Valid/ready channels for font bytes in and pixel writes out.
// ----------------------------------------------------------------------------
interface gbpe_req_if;
   logic                   valid;
   logic                   ready;
   logic [7:0]             font_byte;
   logic                   first_byte;
   logic [9:0]             origin_x;
   logic [9:0]             origin_y;

   modport source (output valid, font_byte, first_byte, origin_x, origin_y, input ready);
   modport sink   (input valid, font_byte, first_byte, origin_x, origin_y, output ready);
endinterface

interface gbpe_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [9:0]             pixel_x;
   logic [9:0]             pixel_y;
   logic [15:0]            pixel_color;
   logic                   last_of_byte;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_of_byte, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_of_byte, output ready);
endinterface

[src/gbpe_ctrl.sv]
// ----------------------------------------------------------------------------
// gbpe_ctrl
// Sequencer: accepts a font byte, then issues one pixel per free output slot.
// ----------------------------------------------------------------------------
module gbpe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gbpe_pkg::cmd_type    cmd,
   input  gbpe_pkg::status_type status
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAW
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      emit;
   logic      load;

   // output slot free or emptying this cycle
   assign emit      = (state_ff == ST_DRAW) && (!rsp_valid_ff || rsp_ready);
   // next byte is taken as the current byte's last pixel goes out
   assign req_ready = (state_ff == ST_IDLE) || (emit && status.last);
   assign load      = req_valid && req_ready;

   assign cmd.load  = load;
   assign cmd.emit  = emit;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (emit && status.last) state_in = load ? ST_DRAW : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/gbpe_dp.sv]
// ----------------------------------------------------------------------------
// gbpe_dp
// Datapath: settings, cursor, bit shifter and the pixel output register.
// ----------------------------------------------------------------------------
module gbpe_dp #(
   parameter int COORD_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gbpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gbpe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [7:0]                        font_byte,
   input  logic                              first_byte,
   input  logic [9:0]                        origin_x,
   input  logic [9:0]                        origin_y,
   output logic [gbpe_pkg::PIX_W-1:0]        pixel_x,
   output logic [gbpe_pkg::PIX_W-1:0]        pixel_y,
   output logic [gbpe_pkg::COLOR_W-1:0]      pixel_color,
   output logic                              last_of_byte,
   input  gbpe_pkg::cmd_type                 cmd,
   output gbpe_pkg::status_type              status
);

   logic [gbpe_pkg::HEIGHT_W-1:0]  height_ff;
   logic [gbpe_pkg::COLOR_W-1:0]   fore_ff;
   logic [gbpe_pkg::COLOR_W-1:0]   back_ff;

   logic [COORD_BITS-1:0]          cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]          cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]          top_ff, top_in;
   logic [gbpe_pkg::BYTE_BITS-1:0] bits_ff, bits_in;
   logic [gbpe_pkg::CNT_W-1:0]     cnt_ff, cnt_in;

   logic [gbpe_pkg::PIX_W-1:0]     pix_x_ff, pix_y_ff;
   logic [gbpe_pkg::COLOR_W-1:0]   color_ff;
   logic                           last_ff;

   logic [COORD_BITS-1:0]          y_inc;
   logic [COORD_BITS-1:0]          y_span;
   logic                           col_done;
   logic                           last;

   assign y_inc    = cur_y_ff + COORD_BITS'(1);
   assign y_span   = y_inc - top_ff;
   assign col_done = (y_span == COORD_BITS'(height_ff));
   assign last     = col_done || (cnt_ff == gbpe_pkg::CNT_W'(gbpe_pkg::BYTE_BITS - 1));

   assign status.last = last;

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      top_in   = top_ff;
      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      if (cmd.emit) begin
         bits_in = {bits_ff[gbpe_pkg::BYTE_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff + gbpe_pkg::CNT_W'(1);
         if (col_done) begin
            cur_y_in = top_ff;
            cur_x_in = cur_x_ff + COORD_BITS'(1);
         end else begin
            cur_y_in = y_inc;
         end
      end
      // a new byte overrides the shift and count step; the cursor reloads from the origin only on a first byte
      if (cmd.load) begin
         bits_in = font_byte;
         cnt_in  = '0;
         if (first_byte) begin
            cur_x_in = COORD_BITS'(origin_x);
            cur_y_in = COORD_BITS'(origin_y);
            top_in   = COORD_BITS'(origin_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= gbpe_pkg::HEIGHT_RESET;
         fore_ff   <= gbpe_pkg::FORE_RESET;
         back_ff   <= gbpe_pkg::BACK_RESET;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         top_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (gbpe_pkg::csr_index_type'(csr_index))
               gbpe_pkg::CSR_GLYPH_HEIGHT: height_ff <= csr_wdata[gbpe_pkg::HEIGHT_W-1:0];
               gbpe_pkg::CSR_FORE_COLOR:   fore_ff   <= csr_wdata;
               gbpe_pkg::CSR_BACK_COLOR:   back_ff   <= csr_wdata;
               default: ;
            endcase
         end
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         top_ff   <= top_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      if (cmd.emit) begin
         pix_x_ff <= gbpe_pkg::PIX_W'(cur_x_ff);
         pix_y_ff <= gbpe_pkg::PIX_W'(cur_y_ff);
         color_ff <= bits_ff[gbpe_pkg::BYTE_BITS-1] ? fore_ff : back_ff;
         last_ff  <= last;
      end
   end

   assign pixel_x      = pix_x_ff;
   assign pixel_y      = pix_y_ff;
   assign pixel_color  = color_ff;
   assign last_of_byte = last_ff;

endmodule

[src/glyph_bitmap_pixel_expander_top.sv]
// ----------------------------------------------------------------------------
// glyph_bitmap_pixel_expander_top
// Expands column-major 1-bit font bytes into colored pixel writes.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                   transfer
//  req_ch    in         font_byte, first_byte, origin_x, origin_y valid & ready
//  rsp_ch    out        pixel_x, pixel_y, pixel_color, last_of_byte valid & ready
//  csr_*     in         csr_index, csr_wdata                      csr_we
//
//  A byte gives 1 to 8 pixels, one per cycle while rsp_ch does not stall; the
//  single pixel output register sets that pace. The next byte is taken in the
//  cycle that issues the current byte's last pixel, so bytes run back to back.
//  A stall on rsp_ch holds the pixel in the output register and pauses issue.
//  Synchronous reset clears the cursor to (0,0) and loads the default settings.
// ----------------------------------------------------------------------------
module glyph_bitmap_pixel_expander_top #(
   parameter int COORD_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   gbpe_req_if.sink                        req_ch,
   gbpe_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [gbpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbpe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   gbpe_pkg::cmd_type    cmd;
   gbpe_pkg::status_type status;

   gbpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   gbpe_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .font_byte    (req_ch.font_byte),
      .first_byte   (req_ch.first_byte),
      .origin_x     (req_ch.origin_x),
      .origin_y     (req_ch.origin_y),
      .pixel_x      (rsp_ch.pixel_x),
      .pixel_y      (rsp_ch.pixel_y),
      .pixel_color  (rsp_ch.pixel_color),
      .last_of_byte (rsp_ch.last_of_byte),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

[src/gbpe_checker.sv]
// ----------------------------------------------------------------------------
// gbpe_checker
// Port-level checks on the pixel output channel of the expander.
// ----------------------------------------------------------------------------
module gbpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  pixel_x,
   input logic [9:0]  pixel_y,
   input logic [15:0] pixel_color,
   input logic        last_of_byte
);

   logic       mid_ff;
   logic [9:0] prev_x_ff;
   logic       rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // track whether the last transfer left a byte unfinished
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else if (rsp_xfer) begin
         mid_ff <= !last_of_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) prev_x_ff <= pixel_x;
   end

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pixel dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pixel_x) && $stable(pixel_y)
         && $stable(pixel_color) && $stable(last_of_byte))
      else $error("pixel changed while stalled");

   // pixels of one byte follow each other without a gap
   a_byte_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !last_of_byte |=> rsp_valid)
      else $error("gap inside a byte");

   // a column never changes before the byte ends
   a_same_column: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && mid_ff |-> pixel_x == prev_x_ff)
      else $error("column moved inside a byte");

endmodule

bind glyph_bitmap_pixel_expander_top gbpe_checker u_gbpe_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .pixel_x      (rsp_ch.pixel_x),
   .pixel_y      (rsp_ch.pixel_y),
   .pixel_color  (rsp_ch.pixel_color),
   .last_of_byte (rsp_ch.last_of_byte)
);
